// ===== rtl/ip4_pkg.sv =====
// Package for the 4x4 intra luma predictor: mode codes, edge layout,
// filter selection codes and the control struct between core and output stage.
// No dependencies.
package ip4_pkg;

	// Pixel depth of the stream; pixel lanes on the ports stay one byte wide.
	localparam int PIXEL_BITS = 8;
	localparam int PIX_W      = 8;

	// Flat mid-grey value, saturated to what a byte lane can carry.
	localparam int GREY_FULL = 1 << (PIXEL_BITS - 1);
	localparam logic [PIX_W-1:0] GREY_VALUE =
		(GREY_FULL > 255) ? 8'hFF : PIX_W'(GREY_FULL);

	// Prediction modes as carried in the request.
	typedef enum logic [3:0] {
		MODE_V     = 4'd0,
		MODE_H     = 4'd1,
		MODE_DC    = 4'd2,
		MODE_DDL   = 4'd3,
		MODE_DDR   = 4'd4,
		MODE_VR    = 4'd5,
		MODE_HD    = 4'd6,
		MODE_VL    = 4'd7,
		MODE_HU    = 4'd8,
		MODE_DCL   = 4'd9,
		MODE_DCT   = 4'd10,
		MODE_DC128 = 4'd11
	} mode_t;

	// What a lane does with the edge pixels around its selected position.
	typedef enum logic [1:0] {
		KIND_COPY = 2'd0,
		KIND_F1   = 2'd1,
		KIND_F2   = 2'd2,
		KIND_DC   = 2'd3
	} kind_t;

	// Edge layout: l3 l3 l2 l1 l0 lt t0..t7 t7 t7. The end pixels are
	// repeated so that a filter reaching past an edge picks them up again.
	typedef logic [15:0][PIX_W-1:0] edge_t;
	localparam logic [3:0] E_L0 = 4'd4;
	localparam logic [3:0] E_LT = 4'd5;
	localparam logic [3:0] E_T0 = 4'd6;

	localparam logic [1:0] LAST_ROW = 2'd3;

	// Load command from the core to the output stage.
	typedef struct packed {
		logic       load;
		logic [1:0] row;
		logic       last;
	} row_ctl_t;

endpackage

// ===== rtl/ip4_if.sv =====
// Channel interfaces of the 4x4 intra luma predictor: request and row result.
// Depends on nothing; widths are fixed by the channel definitions.
interface ip4_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  func;
	logic [7:0]  corner_pixel;
	logic [31:0] left_pixels;
	logic [31:0] top_pixels;
	logic [31:0] top_right_pixels;

	modport source (output valid, func, corner_pixel, left_pixels, top_pixels,
		top_right_pixels, input ready);
	modport sink (input valid, func, corner_pixel, left_pixels, top_pixels,
		top_right_pixels, output ready);
endinterface

interface ip4_row_if;
	logic        valid;
	logic        ready;
	logic [1:0]  row_index;
	logic [31:0] row_pixels;
	logic        last_row;

	modport source (output valid, row_index, row_pixels, last_row, input ready);
	modport sink (input valid, row_index, row_pixels, last_row, output ready);
endinterface

// ===== rtl/ip4_dc.sv =====
// DC value of a request: mean of left and top, of left only, of top only,
// or flat mid-grey. Depends on ip4_pkg.
module ip4_dc
	import ip4_pkg::*;
(
	input  mode_t             mode,
	input  logic [31:0]       left_pixels,
	input  logic [31:0]       top_pixels,
	output logic [PIX_W-1:0]  dc
);

	logic [9:0]  sum_l;
	logic [9:0]  sum_t;
	logic [10:0] sum_all;
	logic [9:0]  rnd_l;
	logic [9:0]  rnd_t;

	// Edge sums, each four bytes wide enough for the rounding term.
	always_comb begin
		sum_l = 10'(left_pixels[7:0]) + 10'(left_pixels[15:8])
			+ 10'(left_pixels[23:16]) + 10'(left_pixels[31:24]);
		sum_t = 10'(top_pixels[7:0]) + 10'(top_pixels[15:8])
			+ 10'(top_pixels[23:16]) + 10'(top_pixels[31:24]);
		sum_all = 11'(sum_l) + 11'(sum_t) + 11'd4;
		rnd_l = sum_l + 10'd2;
		rnd_t = sum_t + 10'd2;
	end

	// Pick the mean that the mode asks for.
	always_comb begin
		unique case (mode)
			MODE_DCL:   dc = rnd_l[9:2];
			MODE_DCT:   dc = rnd_t[9:2];
			MODE_DC128: dc = GREY_VALUE;
			default:    dc = sum_all[10:3];
		endcase
	end

endmodule

// ===== rtl/ip4_lane.sv =====
// One pixel lane: maps row, column and mode to a filter over the edge
// and evaluates it. Depends on ip4_pkg.
module ip4_lane
	import ip4_pkg::*;
(
	input  mode_t             mode,
	input  edge_t             edges,
	input  logic [PIX_W-1:0]  dc,
	input  logic [1:0]        row,
	input  logic [1:0]        col,
	output logic [PIX_W-1:0]  pixel
);

	logic [3:0] y;
	logic [3:0] x;
	logic [3:0] zhu;
	kind_t      kind;
	logic [3:0] ctr;
	logic [PIX_W-1:0] pa;
	logic [PIX_W-1:0] pb;
	logic [PIX_W-1:0] pc;
	logic [8:0] f1;
	logic [9:0] f2;

	assign y   = {2'b00, row};
	assign x   = {2'b00, col};
	assign zhu = x + {y[2:0], 1'b0};

	// Position decoder: which filter and which edge position this pixel uses.
	always_comb begin
		kind = KIND_COPY;
		ctr  = E_T0;
		unique case (mode)
			MODE_V: begin
				ctr = E_T0 + x;
			end
			MODE_H: begin
				ctr = E_L0 - y;
			end
			MODE_DDL: begin
				kind = KIND_F2;
				ctr  = E_T0 + 4'd1 + x + y;
			end
			MODE_DDR: begin
				kind = KIND_F2;
				ctr  = E_LT + x - y;
			end
			MODE_VR: begin
				if (col == 2'd0 && row == 2'd2) begin
					kind = KIND_F2;
					ctr  = E_L0;
				end else if (col == 2'd0 && row == 2'd3) begin
					kind = KIND_F2;
					ctr  = E_L0 - 4'd1;
				end else begin
					kind = row[0] ? KIND_F2 : KIND_F1;
					ctr  = E_LT + x - (y >> 1);
				end
			end
			MODE_HD: begin
				if (row == 2'd0 && col == 2'd2) begin
					kind = KIND_F2;
					ctr  = E_T0;
				end else if (row == 2'd0 && col == 2'd3) begin
					kind = KIND_F2;
					ctr  = E_T0 + 4'd1;
				end else if (col[0]) begin
					kind = KIND_F2;
					ctr  = E_LT - y + (x >> 1);
				end else begin
					kind = KIND_F1;
					ctr  = E_L0 - y + (x >> 1);
				end
			end
			MODE_VL: begin
				kind = row[0] ? KIND_F2 : KIND_F1;
				ctr  = E_T0 + {3'b000, row[0]} + x + (y >> 1);
			end
			MODE_HU: begin
				if (zhu > 4'd5) begin
					kind = KIND_COPY;
					ctr  = 4'd1;
				end else begin
					kind = zhu[0] ? KIND_F2 : KIND_F1;
					ctr  = E_L0 - 4'd1 - (zhu >> 1);
				end
			end
			default: begin
				kind = KIND_DC;
			end
		endcase
	end

	// Neighbor taps around the selected position and the two rounding filters.
	always_comb begin
		pa = edges[ctr - 4'd1];
		pb = edges[ctr];
		pc = edges[ctr + 4'd1];
		f1 = 9'(pb) + 9'(pc) + 9'd1;
		f2 = 10'(pa) + {1'b0, pb, 1'b0} + 10'(pc) + 10'd2;
	end

	always_comb begin
		case (kind)
			KIND_F1: pixel = f1[8:1];
			KIND_F2: pixel = f2[9:2];
			KIND_DC: pixel = dc;
			default: pixel = pb;
		endcase
	end

endmodule

// ===== rtl/ip4_row_out.sv =====
// Output stage: merges the four lane pixels into one row and holds it
// in a register until the receiver takes it. Depends on ip4_pkg, ip4_if.
module ip4_row_out
	import ip4_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  row_ctl_t               ctl,
	input  logic [3:0][PIX_W-1:0]  pixels,
	output logic                   free,
	ip4_row_if.source              rsp
);

	logic        valid_q;
	logic [1:0]  row_q;
	logic        last_q;
	logic [31:0] data_q;

	// The register can take a new row when empty or emptied in this cycle.
	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Row payload, packed with column 0 in the lowest byte.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			row_q  <= ctl.row;
			last_q <= ctl.last;
			data_q <= pixels;
		end
	end

	assign rsp.valid      = valid_q;
	assign rsp.row_index  = row_q;
	assign rsp.last_row   = last_q;
	assign rsp.row_pixels = data_q;

endmodule

// ===== rtl/intra_pred_4x4_luma_core.sv =====
// H.264 4x4 intra luma predictor, top level.
//
// Channel req carries one block request: mode, corner pixel, left column,
// top row and top-right row. Channel rsp returns the prediction as four
// transfers, rows 0 to 3, with last_row set on row 3. Requests with a mode
// code of 12 or above are taken and produce no rows.
//
// A request is registered together with its DC value. Four pixel lanes then
// compute one row per cycle from the stored edge while the output stage is
// free, and the output stage packs the row into its register. Row 0 is shown
// once the request register and then the output register are loaded; rows
// follow one per cycle while rsp.ready is high. The next request is taken in
// the cycle its predecessor's last row moves into the output register.
//
// Reset clears the request and output valid flags and the row counter.
// When the receiver stalls, the shown row holds, the stored request waits,
// and req.ready stays low until the last row of the block moves on.
module intra_pred_4x4_luma_core
	import ip4_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ip4_req_if.sink    req,
	ip4_row_if.source  rsp
);

	logic                   busy_q;
	logic [1:0]             row_q;
	mode_t                  mode_q;
	edge_t                  edge_q;
	logic [PIX_W-1:0]       dc_q;
	logic [PIX_W-1:0]       dc_in;
	edge_t                  edge_in;
	logic                   out_free;
	logic                   advance;
	logic                   last_adv;
	logic                   accept;
	logic                   mode_ok;
	row_ctl_t               ctl;
	logic [3:0][PIX_W-1:0]  pixels;

	// Handshake: a stored block moves one row per cycle into a free output stage.
	assign advance  = busy_q && out_free;
	assign last_adv = advance && (row_q == LAST_ROW);
	assign req.ready = !busy_q || last_adv;
	assign accept   = req.valid && req.ready;
	assign mode_ok  = (req.func <= MODE_DC128);

	// Edge array with the end pixels repeated beyond each end.
	always_comb begin
		edge_in[0]  = req.left_pixels[31:24];
		edge_in[1]  = req.left_pixels[31:24];
		edge_in[2]  = req.left_pixels[23:16];
		edge_in[3]  = req.left_pixels[15:8];
		edge_in[4]  = req.left_pixels[7:0];
		edge_in[5]  = req.corner_pixel;
		edge_in[6]  = req.top_pixels[7:0];
		edge_in[7]  = req.top_pixels[15:8];
		edge_in[8]  = req.top_pixels[23:16];
		edge_in[9]  = req.top_pixels[31:24];
		edge_in[10] = req.top_right_pixels[7:0];
		edge_in[11] = req.top_right_pixels[15:8];
		edge_in[12] = req.top_right_pixels[23:16];
		edge_in[13] = req.top_right_pixels[31:24];
		edge_in[14] = req.top_right_pixels[31:24];
		edge_in[15] = req.top_right_pixels[31:24];
	end

	ip4_dc u_dc (
		.mode        (mode_t'(req.func)),
		.left_pixels (req.left_pixels),
		.top_pixels  (req.top_pixels),
		.dc          (dc_in)
	);

	// Block control: valid flag and row counter of the stored request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= 2'd0;
		end else if (accept) begin
			busy_q <= mode_ok;
			row_q  <= 2'd0;
		end else if (advance) begin
			if (row_q == LAST_ROW) begin
				busy_q <= 1'b0;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	// Stored request payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(req.func);
			edge_q <= edge_in;
			dc_q   <= dc_in;
		end
	end

	// Four lanes, one per column of the current row.
	for (genvar g = 0; g < 4; g++) begin : g_lane
		ip4_lane u_lane (
			.mode  (mode_q),
			.edges (edge_q),
			.dc    (dc_q),
			.row   (row_q),
			.col   (2'(g)),
			.pixel (pixels[g])
		);
	end

	assign ctl.load = advance;
	assign ctl.row  = row_q;
	assign ctl.last = (row_q == LAST_ROW);

	ip4_row_out u_row_out (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pixels (pixels),
		.free   (out_free),
		.rsp    (rsp)
	);

endmodule

// ===== rtl/ip4_checker.sv =====
// Port-level checker for the 4x4 intra luma predictor, bound to the top level.
// Depends on the ports of intra_pred_4x4_luma_core.
module ip4_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_row_index,
	input logic [31:0] rsp_row_pixels,
	input logic        rsp_last_row
);

	// A stalled row holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_pixels)
			&& $stable(rsp_row_index))
		else $error("stalled row changed");

	// The last-row flag marks row 3 and no other.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_last_row == (rsp_row_index == 2'd3))
		else $error("last_row does not match row_index");

	// Rows of one block follow each other without a gap.
	a_row_follows: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp_last_row |=> rsp_valid
			&& rsp_row_index == $past(rsp_row_index) + 2'd1)
		else $error("row sequence broken");

	// When rsp_valid rises, the shown row is row 0.
	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> rsp_row_index == 2'd0)
		else $error("block did not start at row 0");

endmodule

bind intra_pred_4x4_luma_core ip4_checker u_ip4_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_row_index  (rsp.row_index),
	.rsp_row_pixels (rsp.row_pixels),
	.rsp_last_row   (rsp.last_row)
);
